// ===== rtl/core/reed_solomon_parity_encoder_assert.svh =====
// Assertion macros for the Reed-Solomon parity encoder.
// Included by the top level; needs nothing else.
`ifndef REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH
`define REED_SOLOMON_PARITY_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSP_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RSP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/rsp_pkg.sv =====
// Shared types, constants and GF(256) arithmetic for the parity encoder.
// No dependencies.
package rsp_pkg;

    // Low byte of the primitive polynomial 0x11D; the x^8 term is the carry.
    localparam logic [7:0] GF_POLY_LOW = 8'h1D;

    // Parity count after reset.
    localparam logic [5:0] PARITY_RESET = 6'd10;

    // Register decode: address bit 2 selects the register index.
    localparam logic REG_PARITY_COUNT = 1'b0;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One queued data byte with its end-of-block flag.
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } item_t;

    // Back-end status toward the top level.
    typedef struct packed {
        logic absorb;
        logic drain;
    } back_stat_t;

    // GF(256) multiply, shift-and-add over the eight bits of y.
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] a;
        acc = 8'h00;
        a   = x;
        for (int k = 0; k < 8; k++)
        begin
            if (y[k])
            begin
                acc = acc ^ a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

endpackage

// ===== rtl/core/reed_solomon_parity_encoder.sv =====
// A data byte is written into the input queue and then absorbed into the remainder; after
// the last data byte of a block, each parity byte is loaded into the output register.
// Throughput: one data byte per cycle while the queue is not full and no rebuild runs; the
// back end takes no data while it drains a block's n parity bytes, which the output can stall.
// Reset clears the remainder, sets the parity count to 10 and rebuilds the generator; a
// parity count write rebuilds it. No input transaction is taken during a rebuild.
module reed_solomon_parity_encoder #(
    parameter int MAX_PARITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Data input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_data
    // Parity output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] parity_byte, [12:8] parity_index
    output logic        m_tlast     // last_parity
);

    localparam int CNT_W = $clog2(MAX_PARITY + 1);

    logic [5:0]          parity_count_reg;
    logic                cfg_write;
    logic [CNT_W-1:0]    n_eff;
    logic                gen_busy;
    logic [7:0]          coeff [MAX_PARITY + 1];
    logic                q_valid;
    rsp_pkg::item_t      q_item;
    logic                q_pop;
    rsp_pkg::back_stat_t back_stat;

    // Configuration register write and read-back.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == rsp_pkg::REG_PARITY_COUNT);
    assign prdata    = (paddr[2] == rsp_pkg::REG_PARITY_COUNT) ?
                       {26'd0, parity_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_count_reg <= rsp_pkg::PARITY_RESET;
        end
        else if (cfg_write)
        begin
            parity_count_reg <= pwdata[5:0];
        end
    end

    // Effective parity count, clamped to 1..MAX_PARITY.
    always_comb
    begin
        priority if (parity_count_reg == 6'd0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(parity_count_reg) > 32'(MAX_PARITY))
        begin
            n_eff = CNT_W'(MAX_PARITY);
        end
        else
        begin
            n_eff = CNT_W'(parity_count_reg);
        end
    end

    rsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (gen_busy),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rsp_gen #(
        .MAX_PARITY (MAX_PARITY),
        .CNT_W      (CNT_W)
    ) u_gen (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_write),
        .n_eff (n_eff),
        .busy  (gen_busy),
        .coeff (coeff)
    );

    rsp_back #(
        .MAX_PARITY (MAX_PARITY),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (cfg_write),
        .n_eff    (n_eff),
        .coeff    (coeff),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .stat     (back_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Checks on the block's own control.
    `include "reed_solomon_parity_encoder_assert.svh"

    `RSP_ASSERT_NOW(a_no_input_during_build, clk, rst_n, gen_busy, !s_tready)
    `RSP_ASSERT_NEXT(a_write_starts_build, clk, rst_n, cfg_write, gen_busy && back_stat.absorb)
    `RSP_ASSERT_NOW(a_one_back_state, clk, rst_n, 1'b1, back_stat.absorb != back_stat.drain)

endmodule

// ===== rtl/core/rsp_queue.sv =====
// Front end: accepts data bytes from the input stream into a short queue.
// Depends on rsp_pkg.
module rsp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hold,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,
    output logic               q_valid,
    output rsp_pkg::item_t     q_item,
    input  logic               q_pop
);

    localparam int PTR_W = $clog2(rsp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rsp_pkg::QUEUE_DEPTH + 1);

    rsp_pkg::item_t    q_mem_reg [rsp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push;
    logic              pop;

    // No transaction is taken while full or while the generator is rebuilt.
    assign s_tready = (count_reg != CNT_W'(rsp_pkg::QUEUE_DEPTH)) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{last: s_tlast, data: s_tdata};
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/rsp_gen.sv =====
// Generator polynomial builder: multiplies in one root (x + a^i) per cycle.
// Depends on rsp_pkg.
module rsp_gen #(
    parameter int MAX_PARITY = 32,
    parameter int CNT_W      = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] n_eff,
    output logic             busy,
    output logic [7:0]       coeff [MAX_PARITY + 1]
);

    logic [7:0]       gen_reg [MAX_PARITY + 1];
    logic [7:0]       gen_next [MAX_PARITY + 1];
    logic [7:0]       root_reg;
    logic [CNT_W-1:0] step_reg;
    logic             busy_reg;

    // One root step on all coefficients at once; unused high terms stay zero.
    always_comb
    begin
        gen_next[0] = rsp_pkg::gf_mul(gen_reg[0], root_reg);
        for (int j = 1; j <= MAX_PARITY; j++)
        begin
            gen_next[j] = gen_reg[j - 1] ^ rsp_pkg::gf_mul(gen_reg[j], root_reg);
        end
    end

    // Build sequencer; reset and a parity count write both restart it from g(x) = 1.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            root_reg <= 8'h01;
            for (int j = 0; j <= MAX_PARITY; j++)
            begin
                gen_reg[j] <= (j == 0) ? 8'h01 : 8'h00;
            end
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            root_reg <= 8'h01;
            for (int j = 0; j <= MAX_PARITY; j++)
            begin
                gen_reg[j] <= (j == 0) ? 8'h01 : 8'h00;
            end
        end
        else if (busy_reg)
        begin
            gen_reg  <= gen_next;
            root_reg <= rsp_pkg::gf_mul(root_reg, 8'h02);
            step_reg <= step_reg + CNT_W'(1);
            if (step_reg == n_eff - CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy  = busy_reg;
    assign coeff = gen_reg;

endmodule

// ===== rtl/core/rsp_back.sv =====
// Back end: LFSR remainder update per data byte and parity drain per block.
// Depends on rsp_pkg.
module rsp_back #(
    parameter int MAX_PARITY = 32,
    parameter int CNT_W      = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [CNT_W-1:0]    n_eff,
    input  logic [7:0]          coeff [MAX_PARITY + 1],
    input  logic                q_valid,
    input  rsp_pkg::item_t      q_item,
    output logic                q_pop,
    output rsp_pkg::back_stat_t stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [7:0] parity_byte, [12:8] parity_index
    output logic                m_tlast
);

    localparam int IDX_W = $clog2(MAX_PARITY);

    typedef enum logic [1:0] {
        ST_ABSORB = 2'b01,
        ST_DRAIN  = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [7:0]       rem_reg  [MAX_PARITY];
    logic [7:0]       rem_next [MAX_PARITY];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [IDX_W-1:0] top_idx;
    logic [7:0]       top_byte;
    logic [7:0]       factor;
    logic             slot_free;
    logic             load_out;
    logic             drain_last;
    logic [CNT_W+4:0] idx_wide;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [4:0]       out_index_reg;
    logic             out_last_reg;

    // The remainder is held by power of x: entry n-1 is the highest order term.
    assign top_idx    = IDX_W'(n_eff - CNT_W'(1));
    assign top_byte   = rem_reg[top_idx];
    assign factor     = q_item.data ^ top_byte;
    assign slot_free  = !out_valid_reg || m_tready;
    assign drain_last = (cnt_reg == n_eff - CNT_W'(1));
    assign q_pop      = (state_reg == ST_ABSORB);
    assign load_out   = (state_reg == ST_DRAIN) && slot_free;
    assign idx_wide   = {5'b00000, cnt_reg};

    // Next remainder, next state and drain count.
    always_comb
    begin
        rem_next   = rem_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_ABSORB:
            begin
                if (q_valid)
                begin
                    for (int i = 0; i < MAX_PARITY; i++)
                    begin
                        if (CNT_W'(i) < n_eff)
                        begin
                            rem_next[i] = rsp_pkg::gf_mul(coeff[i], factor) ^
                                          ((i == 0) ? 8'h00 : rem_reg[(i == 0) ? 0 : i - 1]);
                        end
                        else
                        begin
                            rem_next[i] = 8'h00;
                        end
                    end
                    if (q_item.last)
                    begin
                        state_next = ST_DRAIN;
                        cnt_next   = '0;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    // Shift toward the top; zeros fill in so the block ends cleared.
                    for (int i = 0; i < MAX_PARITY; i++)
                    begin
                        if ((i != 0) && (CNT_W'(i) < n_eff))
                        begin
                            rem_next[i] = rem_reg[(i == 0) ? 0 : i - 1];
                        end
                        else
                        begin
                            rem_next[i] = 8'h00;
                        end
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (drain_last)
                    begin
                        state_next = ST_ABSORB;
                    end
                end
            end
            default:
            begin
                state_next = ST_ABSORB;
            end
        endcase
    end

    // Remainder and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ABSORB;
            cnt_reg   <= '0;
            for (int i = 0; i < MAX_PARITY; i++)
            begin
                rem_reg[i] <= 8'h00;
            end
        end
        else if (clear)
        begin
            state_reg <= ST_ABSORB;
            cnt_reg   <= '0;
            for (int i = 0; i < MAX_PARITY; i++)
            begin
                rem_reg[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_byte_reg  <= top_byte;
            out_index_reg <= idx_wide[4:0];
            out_last_reg  <= drain_last;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {3'b000, out_index_reg, out_byte_reg};
    assign m_tlast     = out_last_reg;
    assign stat.absorb = (state_reg == ST_ABSORB);
    assign stat.drain  = (state_reg == ST_DRAIN);

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the Reed-Solomon parity encoder.
// Needs rsp_pkg and the reed_solomon_parity_encoder top level; a built-in
// GF(256) encoder computes the expected parity of every block.
module tb;

    localparam int MAX_PARITY = 32;
    localparam logic [7:0] GF_REDUCE = 8'h1D;
    localparam logic [2:0] PARITY_COUNT_ADDR = {rsp_pkg::REG_PARITY_COUNT, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = {~rsp_pkg::REG_PARITY_COUNT, 2'b00};
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } data_beat_t;

    typedef struct packed {
        logic [7:0] value;
        logic [4:0] pos;
        logic       last;
    } parity_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_byte
    logic        s_tlast = 1'b0;   // last_data
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] parity_byte, [12:8] parity_index
    logic        m_tlast;          // last_parity

    // Stimulus and expectation stores.
    data_beat_t   byte_queue [$];
    parity_beat_t parity_due [$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           fail_count = 0;
    int           quiet_cycles = 0;

    // Encoder state mirrored in the testbench.
    logic [5:0] count_reg;
    logic [7:0] gen_coeff [0:MAX_PARITY];
    logic [7:0] rem_bytes [0:MAX_PARITY-1];

    reed_solomon_parity_encoder #(
        .MAX_PARITY(MAX_PARITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock, period 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Multiply in GF(256) modulo x^8 + x^4 + x^3 + x^2 + 1.
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] sum;
        logic [7:0] shifted;
        sum = '0;
        shifted = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                sum = sum ^ shifted;
            end
            shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? GF_REDUCE : 8'h00);
        end
        return sum;
    endfunction

    // The register value clamped to 1..MAX_PARITY.
    function automatic int active_count();
        int n;
        n = int'(count_reg);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_PARITY)
        begin
            n = MAX_PARITY;
        end
        return n;
    endfunction

    // Product of (x + a^i) for i below the active count.
    function automatic void rebuild_generator();
        int n;
        logic [7:0] root;
        n = active_count();
        root = 8'h01;
        for (int j = 0; j <= MAX_PARITY; j++)
        begin
            gen_coeff[j] = '0;
        end
        gen_coeff[0] = 8'h01;
        for (int i = 0; i < n; i++)
        begin
            for (int j = i + 1; j > 0; j--)
            begin
                gen_coeff[j] = gen_coeff[j-1] ^ gf_product(gen_coeff[j], root);
            end
            gen_coeff[0] = gf_product(gen_coeff[0], root);
            root = gf_product(root, 8'h02);
        end
    endfunction

    function automatic void clear_remainder();
        for (int j = 0; j < MAX_PARITY; j++)
        begin
            rem_bytes[j] = '0;
        end
    endfunction

    // A parity count write rebuilds the generator and restarts the block.
    function automatic void apply_parity_count(input logic [31:0] value);
        count_reg = value[5:0];
        rebuild_generator();
        clear_remainder();
    endfunction

    // Shift one data byte into the remainder; on the last byte queue the parity.
    function automatic void encode_byte(input data_beat_t beat);
        int n;
        logic [7:0] factor;
        parity_beat_t out;
        n = active_count();
        factor = beat.data ^ rem_bytes[0];
        for (int j = 0; j + 1 < n; j++)
        begin
            rem_bytes[j] = rem_bytes[j+1];
        end
        rem_bytes[n-1] = '0;
        for (int j = 0; j < n; j++)
        begin
            rem_bytes[j] = rem_bytes[j] ^ gf_product(gen_coeff[n-1-j], factor);
        end
        if (beat.last)
        begin
            for (int k = 0; k < n; k++)
            begin
                out.value = rem_bytes[k];
                out.pos = k[4:0];
                out.last = (k == n - 1);
                parity_due.push_back(out);
            end
            clear_remainder();
        end
    endfunction

    // Data driver: predicts on each accepted transaction and refills from the queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end
        else
        begin
            data_beat_t next_beat;
            if (s_tvalid && s_tready)
            begin
                encode_byte('{last: s_tlast, data: s_tdata});
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_beat.data;
                    s_tlast <= next_beat.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Parity monitor: compares each transaction with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            parity_beat_t want;
            if (m_tvalid && m_tready)
            begin
                if (parity_due.size() == 0)
                begin
                    $error("parity transaction with none expected: data %0h, last %0b",
                           m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = parity_due.pop_front();
                    if (m_tdata[7:0] !== want.value)
                    begin
                        $error("parity_byte: expected %0h, actual %0h", want.value, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[12:8] !== want.pos)
                    begin
                        $error("parity_index: expected %0d, actual %0d", want.pos, m_tdata[12:8]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_parity: expected %0b, actual %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == PARITY_COUNT_ADDR)
        begin
            apply_parity_count(data);
        end
        @(negedge clk);
    endtask

    // Write the parity count with random upper bits and read it back.
    task automatic set_parity_count(input logic [5:0] value);
        logic [31:0] got;
        apb_write(PARITY_COUNT_ADDR, {$urandom} & 32'hFFFF_FFC0 | {26'd0, value});
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= PARITY_COUNT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        if (got !== {26'd0, count_reg})
        begin
            $error("parity_count readback: expected %0d, actual %0d", count_reg, got);
            fail_count++;
        end
    endtask

    // Wait until every queued byte is taken and every parity byte seen,
    // then let the pipeline settle before touching the register.
    task automatic drain();
        while (byte_queue.size() != 0 || s_tvalid || parity_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_byte(input logic [7:0] data, input logic last);
        byte_queue.push_back('{last: last, data: data});
    endtask

    // Whole blocks of random data, mostly short, some long.
    task automatic push_blocks(input int budget);
        int len;
        while (budget > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                push_byte(8'($urandom_range(255)), i == len - 1);
            end
            budget -= len;
        end
    endtask

    initial
    begin
        int send_mode [4];
        int recv_mode [4];
        logic [5:0] pick;
        send_mode = '{0, 69, 0, 18};
        recv_mode = '{0, 0, 69, 18};

        count_reg = rsp_pkg::PARITY_RESET;
        rebuild_generator();
        clear_remainder();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed blocks at the reset parity count.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);
        // Parity count changed in the middle of a block.
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        drain();
        set_parity_count(6'd32);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b1);
        drain();
        // Zero acts as one parity byte.
        set_parity_count(6'd0);
        push_byte(8'hFF, 1'b1);
        drain();
        // Above the maximum clamps to the maximum.
        set_parity_count(6'd63);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFE, 1'b1);
        // A write to an unknown register leaves the block running.
        push_byte(8'hA5, 1'b0);
        drain();
        apb_write(UNUSED_ADDR, $urandom);
        push_byte(8'h5A, 1'b1);
        drain();
        set_parity_count(6'd33);
        push_byte(8'h77, 1'b1);
        drain();
        set_parity_count(6'd1);
        push_byte(8'hE7, 1'b0);
        push_byte(8'h18, 1'b1);
        drain();

        // Random blocks under each idling mode, two parity counts per mode.
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct = send_mode[m];
            recv_stall_pct = recv_mode[m];
            for (int p = 0; p < 2; p++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    pick = $urandom_range(1) ? 6'd32 : 6'd1;
                end
                else
                begin
                    pick = 6'($urandom_range(63));
                end
                set_parity_count(pick);
                push_blocks(30);
                drain();
            end
        end

        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== reed_solomon_parity_encoder.f =====
+incdir+rtl/core
rtl/core/rsp_pkg.sv
rtl/core/rsp_queue.sv
rtl/core/rsp_gen.sv
rtl/core/rsp_back.sv
rtl/core/reed_solomon_parity_encoder.sv
test/tb.sv
